// File: design/ible_pkg.sv
// Package for the indel block list editor: default sizes, operation and
// status codes, and the beat payload types of both channels.
// No dependencies.
package ible_pkg;

  localparam int DEF_MAX_BLOCKS = 32;
  localparam int DEF_LEN_BITS   = 16;
  localparam int FIELD_BITS     = 16;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_BEYOND   = 2'd3
  } status_t;

  typedef struct packed {
    op_t                   operation;
    logic [FIELD_BITS-1:0] position;
    logic [FIELD_BITS-1:0] run_length;
  } in_item_t;

  typedef struct packed {
    status_t               status;
    logic                  block_inserted;
    logic [FIELD_BITS-1:0] block_origin;
    logic [FIELD_BITS-1:0] block_length;
    logic [FIELD_BITS-1:0] total_length;
    logic                  last;
  } out_item_t;

endpackage

// File: design/ible_stream_if.sv
// Valid/ready stream interface carrying one payload per beat.
// Payload type is a parameter; the editor uses the types of ible_pkg.
interface ible_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: design/indel_block_list_editor_top.sv
// Indel block list editor: an ordered segment list (piece table) edited by
// start, insert and delete, and read out one segment per beat.
// Depends on ible_pkg and ible_stream_if.
//
// Usage:
//   req carries one command per beat (operation, position, run_length).
//   rsp carries results: one status beat for start, insert and delete, and
//   one beat per segment for read out (one empty beat for an empty list);
//   last marks the final beat of each command.
//   One command at a time runs under a small sequencer over a single-port
//   segment memory (one read or one write per cycle); req.ready is high
//   only while the sequencer is idle.
//   Insert and delete walk the list segment by segment from the head and
//   shift entries one at a time, each move a read and then a write; read
//   out reads and then emits each segment. The slowest command is a delete
//   that erases every segment from the head.
//   The last beat sits in an output register, so the next command is taken
//   while it waits; a stalled rsp holds the sequencer only with another beat.
//   Reset empties the list and zeroes the length; memory is not cleared.
module indel_block_list_editor_top #(
  parameter int MAX_BLOCKS = ible_pkg::DEF_MAX_BLOCKS,
  parameter int LEN_BITS   = ible_pkg::DEF_LEN_BITS
) (
  input logic          clk,
  input logic          rst,
  ible_stream_if.sink   req,
  ible_stream_if.source rsp
);
  import ible_pkg::*;

  localparam int LW = (LEN_BITS > FIELD_BITS) ? LEN_BITS : FIELD_BITS;
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [LW:0]   LEN_MAX = (LW+1)'((64'd1 << LEN_BITS) - 64'd1);
  localparam logic [CW:0]   CAP     = (CW+1)'(MAX_BLOCKS);
  localparam logic [CW-1:0] ONE     = CW'(1);
  localparam logic [CW-1:0] TWO     = CW'(2);

  typedef struct packed {
    logic          ins;
    logic [LW-1:0] org;
    logic [LW-1:0] len;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE, S_FIN, S_RO_RD, S_RO_EM, S_LOC_RD, S_LOC_CMP, S_INS_ACT,
    S_MU_RD, S_MU_WR, S_INS_W0, S_INS_S1, S_INS_S2, S_INS_S3,
    S_DEL_ACT, S_DEL_STEP, S_DEL_LD, S_DEL_CUR, S_MD_RD, S_MD_WR,
    S_DEL_SP1, S_DEL_SP2
  } state_t;

  entry_t mem [MAX_BLOCKS];
  entry_t rdata, cur;

  state_t        state;
  op_t           op;
  status_t       st;
  logic [LW-1:0] pos, len, off, rem, seq;
  logic [CW-1:0] idx, cnt, k, gap_n;
  logic          o_valid;
  out_item_t     o_item;

  // combinational helpers
  logic [LW-1:0] in_pos, in_len, in_room, avail;
  logic [LW:0]   sum_chk;
  logic [CW-1:0] k_up, idx_p1, idx_p2, k_p1, k_m1;
  logic [CW:0]   need_cnt;
  logic [1:0]    need;
  logic          can_load, o_load;

  assign in_pos   = LW'(req.payload.position);
  assign in_len   = LW'(req.payload.run_length);
  assign in_room  = seq - in_pos;
  assign sum_chk  = {1'b0, seq} + {1'b0, len};
  assign avail    = cur.len - off;
  assign k_up     = k + gap_n;
  assign k_p1     = k + ONE;
  assign k_m1     = k - ONE;
  assign idx_p1   = idx + ONE;
  assign idx_p2   = idx + TWO;
  assign can_load = !o_valid || rsp.ready;
  assign o_load   = ((state == S_FIN) || (state == S_RO_EM)) && can_load;

  // segments an insert needs
  always_comb begin
    if (idx >= cnt)      need = 2'd1;
    else if (cur.ins)    need = 2'd0;
    else if (off == '0)  need = 2'd1;
    else                 need = 2'd2;
  end
  assign need_cnt = {1'b0, cnt} + (CW+1)'(need);

  assign req.ready   = (state == S_IDLE);
  assign rsp.valid   = o_valid;
  assign rsp.payload = o_item;

  // sequencer, segment memory and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      seq     <= '0;
      o_valid <= 1'b0;
    end else begin
      if (rsp.ready && !o_load) o_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op  <= req.payload.operation;
            pos <= in_pos;
            len <= in_len;
            idx <= '0;
            st  <= ST_OK;
            case (req.payload.operation)
              OP_START: begin
                seq   <= in_len;
                cnt   <= (in_len != '0) ? ONE : '0;
                if (in_len != '0) mem[IW'(0)] <= '{ins: 1'b0, org: '0, len: in_len};
                state <= S_FIN;
              end
              OP_INSERT: begin
                state <= (in_len == '0) ? S_FIN : S_LOC_RD;
              end
              OP_DELETE: begin
                if (in_pos >= seq) begin
                  st    <= ST_BEYOND;
                  state <= S_FIN;
                end else begin
                  if (in_len > in_room) len <= in_room;
                  state <= (in_len == '0) ? S_FIN : S_LOC_RD;
                end
              end
              default: state <= S_RO_RD;
            endcase
          end
        end

        // final status beat
        S_FIN: begin
          if (can_load) begin
            o_valid <= 1'b1;
            o_item  <= '{status: st, block_inserted: 1'b0, block_origin: '0,
                         block_length: '0, total_length: seq[FIELD_BITS-1:0],
                         last: 1'b1};
            state   <= S_IDLE;
          end
        end

        // read out
        S_RO_RD: begin
          if (cnt == '0) begin
            state <= S_FIN;
          end else begin
            rdata <= mem[idx[IW-1:0]];
            state <= S_RO_EM;
          end
        end
        S_RO_EM: begin
          if (can_load) begin
            o_valid <= 1'b1;
            o_item  <= '{status: ST_OK, block_inserted: rdata.ins,
                         block_origin: rdata.ins ? '0 : rdata.org[FIELD_BITS-1:0],
                         block_length: rdata.len[FIELD_BITS-1:0],
                         total_length: seq[FIELD_BITS-1:0],
                         last: (idx_p1 == cnt)};
            idx     <= idx_p1;
            state   <= (idx_p1 == cnt) ? S_IDLE : S_RO_RD;
          end
        end

        // walk to the segment holding pos
        S_LOC_RD: begin
          if (op == OP_INSERT && sum_chk > LEN_MAX) begin
            st    <= ST_OVERFLOW;
            state <= S_FIN;
          end else if (idx < cnt) begin
            rdata <= mem[idx[IW-1:0]];
            state <= S_LOC_CMP;
          end else begin
            off   <= pos;
            state <= (op == OP_INSERT) ? S_INS_ACT : S_DEL_ACT;
          end
        end
        S_LOC_CMP: begin
          if (pos >= rdata.len) begin
            pos   <= pos - rdata.len;
            idx   <= idx_p1;
            state <= S_LOC_RD;
          end else begin
            off   <= pos;
            cur   <= rdata;
            state <= (op == OP_INSERT) ? S_INS_ACT : S_DEL_ACT;
          end
        end

        // insert
        S_INS_ACT: begin
          if (need_cnt > CAP) begin
            st    <= ST_FULL;
            state <= S_FIN;
          end else if (idx >= cnt) begin
            mem[idx[IW-1:0]] <= '{ins: 1'b1, org: '0, len: len};
            cnt   <= idx_p1;
            seq   <= seq + len;
            state <= S_FIN;
          end else if (cur.ins) begin
            mem[idx[IW-1:0]] <= '{ins: 1'b1, org: cur.org, len: cur.len + len};
            seq   <= seq + len;
            state <= S_FIN;
          end else if (off == '0) begin
            k     <= cnt;
            gap_n <= ONE;
            state <= S_MU_RD;
          end else begin
            k     <= cnt;
            gap_n <= TWO;
            state <= S_MU_RD;
          end
        end

        // open a gap: shift entries up by gap_n, from the end down
        S_MU_RD: begin
          if (k > ((op == OP_INSERT && off == '0) ? idx : idx_p1)) begin
            rdata <= mem[k_m1[IW-1:0]];
            k     <= k_m1;
            state <= S_MU_WR;
          end else begin
            cnt <= cnt + gap_n;
            if (op == OP_INSERT) state <= (off == '0) ? S_INS_W0 : S_INS_S1;
            else                 state <= S_DEL_SP1;
          end
        end
        S_MU_WR: begin
          mem[k_up[IW-1:0]] <= rdata;
          state <= S_MU_RD;
        end

        S_INS_W0: begin
          mem[idx[IW-1:0]] <= '{ins: 1'b1, org: '0, len: len};
          seq   <= seq + len;
          state <= S_FIN;
        end
        S_INS_S1: begin
          mem[idx_p2[IW-1:0]] <= '{ins: 1'b0, org: cur.org + off, len: cur.len - off};
          state <= S_INS_S2;
        end
        S_INS_S2: begin
          mem[idx_p1[IW-1:0]] <= '{ins: 1'b1, org: '0, len: len};
          state <= S_INS_S3;
        end
        S_INS_S3: begin
          mem[idx[IW-1:0]] <= '{ins: cur.ins, org: cur.org, len: off};
          seq   <= seq + len;
          state <= S_FIN;
        end

        // delete
        S_DEL_ACT: begin
          if (idx >= cnt) begin
            st    <= ST_BEYOND;
            state <= S_FIN;
          end else if (!cur.ins && off != '0 && (off + len) < cur.len &&
                       {1'b0, cnt} >= CAP) begin
            st    <= ST_FULL;
            state <= S_FIN;
          end else begin
            rem   <= len;
            state <= S_DEL_STEP;
          end
        end
        S_DEL_STEP: begin
          if (rem == '0 || idx >= cnt) begin
            seq   <= seq - len;
            state <= S_FIN;
          end else if (rem >= avail) begin
            rem <= rem - avail;
            off <= '0;
            if (off == '0) begin
              k     <= idx;
              state <= S_MD_RD;
            end else begin
              mem[idx[IW-1:0]] <= '{ins: cur.ins, org: cur.org, len: off};
              idx   <= idx_p1;
              state <= S_DEL_LD;
            end
          end else if (cur.ins) begin
            mem[idx[IW-1:0]] <= '{ins: 1'b1, org: cur.org, len: cur.len - rem};
            rem <= '0;
          end else if (off == '0) begin
            mem[idx[IW-1:0]] <= '{ins: 1'b0, org: cur.org + rem, len: cur.len - rem};
            rem <= '0;
          end else begin
            k     <= cnt;
            gap_n <= ONE;
            state <= S_MU_RD;
          end
        end
        S_DEL_LD: begin
          if (idx < cnt) begin
            rdata <= mem[idx[IW-1:0]];
            state <= S_DEL_CUR;
          end else begin
            state <= S_DEL_STEP;
          end
        end
        S_DEL_CUR: begin
          cur   <= rdata;
          state <= S_DEL_STEP;
        end

        // close a gap: shift entries down by one
        S_MD_RD: begin
          if (k_p1 < cnt) begin
            rdata <= mem[k_p1[IW-1:0]];
            state <= S_MD_WR;
          end else begin
            cnt   <= cnt - ONE;
            state <= S_DEL_LD;
          end
        end
        S_MD_WR: begin
          mem[k[IW-1:0]] <= rdata;
          k     <= k_p1;
          state <= S_MD_RD;
        end

        // split an original run around the deleted span
        S_DEL_SP1: begin
          mem[idx_p1[IW-1:0]] <= '{ins: 1'b0, org: cur.org + off + rem,
                                   len: cur.len - off - rem};
          state <= S_DEL_SP2;
        end
        S_DEL_SP2: begin
          mem[idx[IW-1:0]] <= '{ins: cur.ins, org: cur.org, len: off};
          rem   <= '0;
          state <= S_DEL_STEP;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sim/ible_edit_checker.sv
// Checker for the indel block list editor: watches the req and rsp channels,
// keeps its own segment list and compares every rsp beat with its prediction.
// Depends on ible_pkg and ible_stream_if.
module ible_edit_checker #(
  parameter int MAX_BLOCKS = ible_pkg::DEF_MAX_BLOCKS,
  parameter int LEN_BITS   = ible_pkg::DEF_LEN_BITS
) (
  input  logic       clk,
  input  logic       rst,
  ible_stream_if.sink req_mon,
  ible_stream_if.sink rsp_mon,
  output int         errors,
  output int         pending,
  output int         beats_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import ible_pkg::*;

  // shadow of the segment list
  logic        shadow_ins [MAX_BLOCKS];
  int unsigned shadow_org [MAX_BLOCKS];
  int unsigned shadow_len [MAX_BLOCKS];
  int unsigned shadow_count;
  int unsigned shadow_total;

  out_item_t expected_beats[$];

  function automatic longint unsigned len_ceiling();
    return (longint'(1) << LEN_BITS) - 1;
  endfunction

  // append one predicted beat
  function automatic void queue_beat(out_item_t b);
    expected_beats.insert(expected_beats.size(), b);
  endfunction

  // open n slots at index at
  function automatic void open_slots(int unsigned at, int unsigned n);
    int unsigned k;
    k = shadow_count;
    while (k > at) begin
      k--;
      if (k + n < MAX_BLOCKS) begin
        shadow_ins[k+n] = shadow_ins[k];
        shadow_org[k+n] = shadow_org[k];
        shadow_len[k+n] = shadow_len[k];
      end
    end
    shadow_count += n;
  endfunction

  function automatic void drop_slot(int unsigned at);
    for (int unsigned k = at; k + 1 < shadow_count; k++) begin
      shadow_ins[k] = shadow_ins[k+1];
      shadow_org[k] = shadow_org[k+1];
      shadow_len[k] = shadow_len[k+1];
    end
    if (shadow_count > 0) shadow_count--;
  endfunction

  function automatic int unsigned find_seg(int unsigned pos, output int unsigned off);
    int unsigned i;
    i = 0;
    while (i < shadow_count && pos >= shadow_len[i]) begin
      pos -= shadow_len[i];
      i++;
    end
    off = pos;
    return i;
  endfunction

  function automatic status_t apply_insert(int unsigned pos, int unsigned len);
    int unsigned off, i, need;
    if (len == 0) return ST_OK;
    if (longint'(shadow_total) + len > len_ceiling()) return ST_OVERFLOW;
    i = find_seg(pos, off);
    if (i >= shadow_count) need = 1;
    else if (shadow_ins[i]) need = 0;
    else if (off == 0) need = 1;
    else need = 2;
    if (shadow_count + need > MAX_BLOCKS) return ST_FULL;
    if (i >= shadow_count) begin
      shadow_ins[i] = 1'b1; shadow_org[i] = 0; shadow_len[i] = len;
      shadow_count++;
    end else if (shadow_ins[i]) begin
      shadow_len[i] += len;
    end else if (off == 0) begin
      open_slots(i, 1);
      shadow_ins[i] = 1'b1; shadow_org[i] = 0; shadow_len[i] = len;
    end else begin
      open_slots(i + 1, 2);
      shadow_ins[i+2] = 1'b0;
      shadow_org[i+2] = shadow_org[i] + off;
      shadow_len[i+2] = shadow_len[i] - off;
      shadow_ins[i+1] = 1'b1; shadow_org[i+1] = 0; shadow_len[i+1] = len;
      shadow_len[i] = off;
    end
    shadow_total += len;
    return ST_OK;
  endfunction

  function automatic status_t apply_delete(int unsigned pos, int unsigned len);
    int unsigned off, rem, i, avail;
    if (pos >= shadow_total) return ST_BEYOND;
    if (len > shadow_total - pos) len = shadow_total - pos;
    if (len == 0) return ST_OK;
    i = find_seg(pos, off);
    if (i >= shadow_count) return ST_BEYOND;
    // a split inside an original run needs one more slot
    if (!shadow_ins[i] && off > 0 && off + len < shadow_len[i] &&
        shadow_count >= MAX_BLOCKS)
      return ST_FULL;
    rem = len;
    while (rem > 0 && i < shadow_count) begin
      avail = shadow_len[i] - off;
      if (rem >= avail) begin
        rem -= avail;
        if (off == 0) drop_slot(i);
        else begin
          shadow_len[i] = off;
          i++;
        end
        off = 0;
      end else begin
        if (shadow_ins[i]) shadow_len[i] -= rem;
        else if (off == 0) begin
          shadow_org[i] += rem;
          shadow_len[i] -= rem;
        end else begin
          open_slots(i + 1, 1);
          shadow_ins[i+1] = 1'b0;
          shadow_org[i+1] = shadow_org[i] + off + rem;
          shadow_len[i+1] = shadow_len[i] - off - rem;
          shadow_len[i] = off;
        end
        rem = 0;
      end
    end
    shadow_total -= len;
    return ST_OK;
  endfunction

  function automatic out_item_t make_beat(status_t st, logic ins, int unsigned org,
                                          int unsigned len, logic fin);
    out_item_t b;
    b.status         = st;
    b.block_inserted = ins;
    b.block_origin   = org[FIELD_BITS-1:0];
    b.block_length   = len[FIELD_BITS-1:0];
    b.total_length   = shadow_total[FIELD_BITS-1:0];
    b.last           = fin;
    return b;
  endfunction

  // predict the beats caused by one command
  function automatic void predict_command(in_item_t cmd);
    status_t st;
    st = ST_OK;
    case (cmd.operation)
      OP_READ: begin
        if (shadow_count == 0)
          queue_beat(make_beat(ST_OK, 1'b0, 0, 0, 1'b1));
        for (int unsigned k = 0; k < shadow_count; k++)
          queue_beat(make_beat(ST_OK, shadow_ins[k],
            shadow_ins[k] ? 0 : shadow_org[k], shadow_len[k], k + 1 == shadow_count));
      end
      OP_START: begin
        shadow_count = 0;
        shadow_total = 0;
        if (cmd.run_length != 0) begin
          shadow_ins[0] = 1'b0; shadow_org[0] = 0; shadow_len[0] = cmd.run_length;
          shadow_count = 1;
          shadow_total = cmd.run_length;
        end
      end
      OP_INSERT: st = apply_insert(cmd.position, cmd.run_length);
      default:   st = apply_delete(cmd.position, cmd.run_length);
    endcase
    if (cmd.operation != OP_READ)
      queue_beat(make_beat(st, 1'b0, 0, 0, 1'b1));
  endfunction

  // monitor both channels at each edge
  always @(posedge clk) begin
    out_item_t want, got;
    if (rst) begin
      shadow_count = 0;
      shadow_total = 0;
      errors       <= 0;
      beats_seen   <= 0;
      pending      <= 0;
      expected_beats.delete();
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = rsp_mon.payload;
        beats_seen <= beats_seen + 1;
        if (expected_beats.size() == 0) begin
          $error("unexpected rsp beat %p", got);
          errors <= errors + 1;
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) begin
            errors <= errors + 1;
            if (got.status !== want.status)
              $error("status: expected %0d actual %0d", want.status, got.status);
            if (got.block_inserted !== want.block_inserted)
              $error("block_inserted: expected %0d actual %0d",
                     want.block_inserted, got.block_inserted);
            if (got.block_origin !== want.block_origin)
              $error("block_origin: expected %0d actual %0d",
                     want.block_origin, got.block_origin);
            if (got.block_length !== want.block_length)
              $error("block_length: expected %0d actual %0d",
                     want.block_length, got.block_length);
            if (got.total_length !== want.total_length)
              $error("total_length: expected %0d actual %0d",
                     want.total_length, got.total_length);
            if (got.last !== want.last)
              $error("last: expected %0d actual %0d", want.last, got.last);
          end
        end
      end
      // command predicted after the beat check: a new command's beats come later
      if (req_mon.valid && req_mon.ready) predict_command(req_mon.payload);
      pending <= expected_beats.size();
    end
  end
endmodule

// File: sim/indel_block_list_editor_top_test.sv
// Testbench top for the indel block list editor: clock, reset, command
// stimulus with random gaps and rsp stalls, and the verdict.
// Depends on ible_pkg, ible_stream_if, ible_edit_checker and the editor RTL.
module indel_block_list_editor_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ible_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic clk;
  logic rst;
  int   errors, pending, beats_seen;
  int   cycles = 0;
  int   cmd_count;
  bit   stall_long;
  bit   rsp_quiet;

  ible_stream_if #(.payload_t(in_item_t))  req ();
  ible_stream_if #(.payload_t(out_item_t)) rsp ();

  indel_block_list_editor_top i_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  ible_edit_checker i_checker (
    .clk(clk), .rst(rst), .req_mon(req), .rsp_mon(rsp),
    .errors(errors), .pending(pending), .beats_seen(beats_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // rsp stalls: mostly short, some long, stretches with none
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (rst || rsp_quiet) rsp.ready <= 1'b1;
    else if (r < 60) rsp.ready <= 1'b1;
    else if (r < 97) rsp.ready <= 1'b0;
    else begin
      rsp.ready <= 1'b0;
      repeat ($urandom_range(5, 30)) @(posedge clk);
    end
  end

  // one command beat, then a random gap
  task automatic send_cmd(op_t op, logic [15:0] pos, logic [15:0] len);
    int gap;
    req.valid   <= 1'b1;
    req.payload <= '{operation: op, position: pos, run_length: len};
    do @(posedge clk); while (!(req.ready === 1'b1));
    cmd_count++;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 2);
    if (stall_long) gap = 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 16'($urandom_range(0, 40));
    if (r < 9) return 16'($urandom_range(0, 2000));
    return 16'($urandom);
  endfunction

  initial begin
    int r;
    op_t op;
    rst         = 1'b1;
    cmd_count   = 0;
    stall_long  = 0;
    rsp_quiet   = 0;
    req.valid   = 1'b0;
    req.payload = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty list, extremes, every split and trim case
    send_cmd(OP_READ, 16'hffff, 16'hffff);
    send_cmd(OP_START, 0, 0);
    send_cmd(OP_READ, 0, 0);
    send_cmd(OP_INSERT, 16'hffff, 5);      // append on empty list
    send_cmd(OP_INSERT, 0, 16'hffff);      // length overflow
    send_cmd(OP_START, 0, 100);
    send_cmd(OP_INSERT, 0, 7);             // before an original run
    send_cmd(OP_INSERT, 7, 3);             // end of inserted run
    send_cmd(OP_INSERT, 3, 2);             // grows inserted run
    send_cmd(OP_INSERT, 50, 4);            // splits an original run
    send_cmd(OP_INSERT, 500, 6);           // appended past end
    send_cmd(OP_INSERT, 10, 0);            // zero length
    send_cmd(OP_READ, 0, 0);
    send_cmd(OP_DELETE, 1000, 1);          // beyond end
    send_cmd(OP_DELETE, 5, 0);
    send_cmd(OP_DELETE, 30, 5);            // inner split
    send_cmd(OP_DELETE, 12, 2);            // head trim
    send_cmd(OP_DELETE, 2, 40);            // spans several
    send_cmd(OP_DELETE, 20, 16'hffff);     // clipped
    send_cmd(OP_READ, 0, 0);
    send_cmd(OP_START, 0, 16'hffff);
    send_cmd(OP_INSERT, 1, 1);
    send_cmd(OP_DELETE, 0, 16'hffff);
    send_cmd(OP_READ, 0, 0);

    // pause until every beat is back
    drain();

    // random: well-formed edit sessions
    while (cmd_count < 209) begin
      if ($urandom_range(0, 9) == 0) begin
        rsp_quiet  = 1'($urandom_range(0, 1));
        stall_long = 1'($urandom_range(0, 1));
      end
      r = $urandom_range(0, 99);
      if (r < 4) send_cmd(OP_START, 16'($urandom), ($urandom_range(0, 5) == 0) ? 16'd0 :
                          16'($urandom_range(1, 3000)));
      else if (r < 14) send_cmd(OP_READ, 16'($urandom), 16'($urandom));
      else begin
        op = (r < 60) ? OP_INSERT : OP_DELETE;
        if ($urandom_range(0, 7) == 0)
          send_cmd(op, 16'($urandom), 16'($urandom));
        else
          send_cmd(op, 16'($urandom_range(0, 3200)), pick_len());
      end
    end
    send_cmd(OP_READ, 0, 0);
    rsp_quiet = 0;
    drain();
    repeat (200) @(posedge clk);

    $display("covered %0d start, insert, delete and read out commands under random gaps",
             cmd_count);
    $display("and rsp stalls, with %0d rsp beats checked", beats_seen);
    if (errors == 0 && pending == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

// File: files.f
design/ible_pkg.sv
design/ible_stream_if.sv
design/indel_block_list_editor_top.sv
sim/ible_edit_checker.sv
sim/indel_block_list_editor_top_test.sv
